/* hdl/assert_macros.svh */
// assertion helpers used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/csrast_pkg.sv */
`default_nettype none

package csrast_pkg;

   localparam int COORD_W  = 15;
   localparam int RADIUS_W = 5;
   localparam int SPAN_W   = 16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EMIT_POS,
      ST_EMIT_NEG
   } state_type;

   typedef enum logic [1:0] {
      ALU_HOLD,
      ALU_LOAD,
      ALU_SHRINK,
      ALU_ADVANCE
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic       emit;
      logic       emit_neg;
      logic       last;
   } ctl_type;

   typedef struct packed {
      logic w_zero;
      logic d_neg;
      logic i_last;
   } stat_type;

endpackage

`default_nettype wire

/* hdl/csrast_req_if.sv */
`default_nettype none

interface csrast_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [csrast_pkg::COORD_W-1:0]     center_x;
   logic signed [csrast_pkg::COORD_W-1:0]     center_y;
   logic        [csrast_pkg::RADIUS_W-1:0]    radius;

   modport source (output valid, output center_x, output center_y, output radius,
                   input ready);
   modport sink   (input valid, input center_x, input center_y, input radius,
                   output ready);
endinterface

`default_nettype wire

/* hdl/csrast_rsp_if.sv */
`default_nettype none

interface csrast_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [csrast_pkg::SPAN_W-1:0]  span_row;
   logic signed [csrast_pkg::SPAN_W-1:0]  span_left;
   logic signed [csrast_pkg::SPAN_W-1:0]  span_right;
   logic                                  last_span;

   modport source (output valid, output span_row, output span_left, output span_right,
                   output last_span, input ready);
   modport sink   (input valid, input span_row, input span_left, input span_right,
                   input last_span, output ready);
endinterface

`default_nettype wire

/* hdl/csrast_ctrl.sv */
`default_nettype none

module csrast_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire                   r_zero,
   input  wire                   out_free,
   input  csrast_pkg::stat_type  stat,
   output logic                  idle,
   output csrast_pkg::ctl_type   ctl
);

   csrast_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csrast_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csrast_pkg::ST_IDLE: begin
            if (start && !r_zero) state_in = csrast_pkg::ST_CHECK;
         end
         csrast_pkg::ST_CHECK: begin
            if (stat.w_zero || !stat.d_neg) state_in = csrast_pkg::ST_EMIT_POS;
         end
         csrast_pkg::ST_EMIT_POS: begin
            if (out_free) state_in = csrast_pkg::ST_EMIT_NEG;
         end
         csrast_pkg::ST_EMIT_NEG: begin
            if (out_free) begin
               state_in = stat.i_last ? csrast_pkg::ST_IDLE : csrast_pkg::ST_CHECK;
            end
         end
         default: state_in = csrast_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      idle         = 1'b0;
      ctl.op       = csrast_pkg::ALU_HOLD;
      ctl.emit     = 1'b0;
      ctl.emit_neg = 1'b0;
      ctl.last     = 1'b0;
      case (state_ff)
         csrast_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (start) ctl.op = csrast_pkg::ALU_LOAD;
         end
         csrast_pkg::ST_CHECK: begin
            // error term negative means the half-width is still too wide
            if (!stat.w_zero && stat.d_neg) ctl.op = csrast_pkg::ALU_SHRINK;
         end
         csrast_pkg::ST_EMIT_POS: begin
            ctl.emit = out_free;
         end
         csrast_pkg::ST_EMIT_NEG: begin
            if (out_free) begin
               ctl.emit     = 1'b1;
               ctl.emit_neg = 1'b1;
               ctl.last     = stat.i_last;
               ctl.op       = csrast_pkg::ALU_ADVANCE;
            end
         end
         default: idle = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/csrast_alu.sv */
`default_nettype none

module csrast_alu #(
   parameter int RW = 5
) (
   input  wire                        clock,
   input  csrast_pkg::alu_op_type     op,
   input  wire  [RW-1:0]              r_load,
   output logic [RW-1:0]              w,
   output logic [RW-1:0]              i,
   output csrast_pkg::stat_type       stat
);

   // error term d = r*r - w*w - i*i, kept exactly through one shared adder
   localparam int DW = RW + 3;

   logic        [RW-1:0] w_ff, w_in;
   logic        [RW-1:0] i_ff, i_in;
   logic        [RW-1:0] r_ff, r_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic signed [DW-1:0] operand;
   logic signed [DW-1:0] sum;

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      i_ff <= i_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   // shrink adds 2w-1, advance adds -(2i+1) which is ~(2i)
   always_comb begin
      if (op == csrast_pkg::ALU_SHRINK) begin
         operand = {2'b00, w_ff, 1'b0} - DW'(1);
      end else begin
         operand = ~{2'b00, i_ff, 1'b0};
      end
      sum = d_ff + operand;
   end

   always_comb begin
      w_in = w_ff;
      i_in = i_ff;
      r_in = r_ff;
      d_in = d_ff;
      case (op)
         csrast_pkg::ALU_LOAD: begin
            w_in = r_load;
            i_in = '0;
            r_in = r_load;
            d_in = '0;
         end
         csrast_pkg::ALU_SHRINK: begin
            w_in = w_ff - RW'(1);
            d_in = sum;
         end
         csrast_pkg::ALU_ADVANCE: begin
            i_in = i_ff + RW'(1);
            d_in = sum;
         end
         default: d_in = d_ff;
      endcase
   end

   assign w           = w_ff;
   assign i           = i_ff;
   assign stat.w_zero = (w_ff == '0);
   assign stat.d_neg  = d_ff[DW-1];
   assign stat.i_last = (i_ff == r_ff - RW'(1));

endmodule

`default_nettype wire

/* hdl/csrast_span.sv */
`default_nettype none

module csrast_span #(
   parameter int RW = 5
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   load_xy,
   input  wire signed [csrast_pkg::COORD_W-1:0]  center_x,
   input  wire signed [csrast_pkg::COORD_W-1:0]  center_y,
   input  csrast_pkg::ctl_type                   ctl,
   input  wire        [RW-1:0]                   w,
   input  wire        [RW-1:0]                   i,
   output logic                                  out_free,
   csrast_rsp_if.source                          rsp
);

   localparam int SW = csrast_pkg::SPAN_W;

   logic signed [csrast_pkg::COORD_W-1:0] cx_ff, cx_in;
   logic signed [csrast_pkg::COORD_W-1:0] cy_ff, cy_in;
   logic                                  valid_ff, valid_in;
   logic signed [SW-1:0]                  row_ff, row_in;
   logic signed [SW-1:0]                  left_ff, left_in;
   logic signed [SW-1:0]                  right_ff, right_in;
   logic                                  last_ff, last_in;
   logic signed [SW-1:0]                  cx_ext, cy_ext, w_ext, i_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      row_ff   <= row_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      last_ff  <= last_in;
   end

   assign out_free = !valid_ff || rsp.ready;

   always_comb begin
      cx_ext = {cx_ff[csrast_pkg::COORD_W-1], cx_ff};
      cy_ext = {cy_ff[csrast_pkg::COORD_W-1], cy_ff};
      w_ext  = {{(SW-RW){1'b0}}, w};
      i_ext  = {{(SW-RW){1'b0}}, i};

      cx_in    = load_xy ? center_x : cx_ff;
      cy_in    = load_xy ? center_y : cy_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      right_in = right_ff;
      last_in  = last_ff;
      valid_in = valid_ff;

      if (ctl.emit) begin
         row_in   = ctl.emit_neg ? (cy_ext - i_ext) : (cy_ext + i_ext);
         left_in  = cx_ext - w_ext;
         right_in = cx_ext + w_ext;
         last_in  = ctl.last;
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.span_row   = row_ff;
   assign rsp.span_left  = left_ff;
   assign rsp.span_right = right_ff;
   assign rsp.last_span  = last_ff;

endmodule

`default_nettype wire

/* hdl/circle_span_rasterizer_core.sv */
// channel   dir   fields                                        transfer
// req_if    in    center_x, center_y, radius                    valid && ready
// rsp_if    out   span_row, span_left, span_right, last_span    valid && ready
//
// a circle is accepted, then each row has a check that shrinks the half-width
// one step at a time while the error term is negative, then two spans: row
// cy+i, then row cy-i. the error term is kept by the single shared adder.
// radius 0 is accepted and gives no spans; a new circle is taken only when idle.
// a full output register stalls the sequencer; the last span may wait while
// the next circle is accepted. reset clears the sequencer and output valid.
`default_nettype none

`include "assert_macros.svh"

module circle_span_rasterizer_core #(
   parameter int MAX_RADIUS = 31
) (
   input  wire           clock,
   input  wire           reset,
   csrast_req_if.sink    req_if,
   csrast_rsp_if.source  rsp_if
);

   localparam int RW = $clog2(MAX_RADIUS + 1);

   csrast_pkg::ctl_type  ctl;
   csrast_pkg::stat_type stat;
   logic                 idle;
   logic                 start;
   logic                 out_free;
   logic                 r_zero;
   logic [RW-1:0]        r_sat;
   logic [RW-1:0]        w;
   logic [RW-1:0]        i;

   assign req_if.ready = idle;
   assign start        = req_if.valid && idle;
   assign r_zero       = (req_if.radius == '0);

   always_comb begin
      if (32'(req_if.radius) > MAX_RADIUS) begin
         r_sat = RW'(MAX_RADIUS);
      end else begin
         r_sat = RW'(req_if.radius);
      end
   end

   csrast_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .r_zero   (r_zero),
      .out_free (out_free),
      .stat     (stat),
      .idle     (idle),
      .ctl      (ctl)
   );

   csrast_alu #(.RW(RW)) u_alu (
      .clock  (clock),
      .op     (ctl.op),
      .r_load (r_sat),
      .w      (w),
      .i      (i),
      .stat   (stat)
   );

   csrast_span #(.RW(RW)) u_span (
      .clock    (clock),
      .reset    (reset),
      .load_xy  (start),
      .center_x (req_if.center_x),
      .center_y (req_if.center_y),
      .ctl      (ctl),
      .w        (w),
      .i        (i),
      .out_free (out_free),
      .rsp      (rsp_if)
   );

   `ASSERT_IMPLIES(a_span_order, clock, reset, rsp_if.valid, rsp_if.span_left <= rsp_if.span_right, "span left edge beyond right edge")
   `ASSERT_IMPLIES(a_floor_holds, clock, reset, ctl.op == csrast_pkg::ALU_HOLD && !idle && !ctl.emit && stat.w_zero, !stat.d_neg, "half-width floor reached with error term negative")
   `ASSERT_NEXT(a_last_to_idle, clock, reset, ctl.emit && ctl.last, req_if.ready, "sequencer not idle after last span")

endmodule

`default_nettype wire

/* test/tb_circle_span_rasterizer_core.sv */
module tb_circle_span_rasterizer_core;

   localparam int MAX_RADIUS   = 31;
   localparam int COORD_W      = csrast_pkg::COORD_W;
   localparam int RADIUS_W     = csrast_pkg::RADIUS_W;
   localparam int SPAN_W       = csrast_pkg::SPAN_W;
   localparam int N_RANDOM     = 180;
   localparam int LONG_HOLD_AT = 150;   // transfer count at which the sink backs off
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_AT     = 120;   // random item that waits for an empty pipe

   typedef struct {
      logic signed [COORD_W-1:0]  cx;
      logic signed [COORD_W-1:0]  cy;
      logic        [RADIUS_W-1:0] radius;
      int unsigned                gap;
      bit                         drain;
   } circle_type;

   typedef struct {
      logic signed [SPAN_W-1:0] row;
      logic signed [SPAN_W-1:0] left;
      logic signed [SPAN_W-1:0] right;
      logic                     last;
   } span_type;

   logic clock = 1'b0;
   logic reset;

   csrast_req_if req_ch ();
   csrast_rsp_if rsp_ch ();

   circle_span_rasterizer_core #(
      .MAX_RADIUS(MAX_RADIUS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   circle_type  circle_q[$];
   span_type    span_q[$];
   circle_type  in_flight;
   int          n_circles;
   int          circles_taken;
   int unsigned idle_cnt;
   int unsigned stall_left;
   int          spans_seen;
   int          n_errors;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // expected spans of one circle, in emission order
   function automatic void rasterize_circle(circle_type c);
      int       r, w, x, y;
      span_type s;
      r = int'(c.radius);
      if (r > MAX_RADIUS)
         r = MAX_RADIUS;
      w = r;
      x = int'(c.cx);
      y = int'(c.cy);
      for (int i = 0; i < r; i++) begin
         while (w > 0 && w * w + i * i > r * r)
            w--;
         s.left  = SPAN_W'(x - w);
         s.right = SPAN_W'(x + w);
         s.row   = SPAN_W'(y + i);
         s.last  = 1'b0;
         span_q.push_back(s);
         s.row   = SPAN_W'(y - i);
         s.last  = (i == r - 1);
         span_q.push_back(s);
      end
   endfunction

   function automatic void add_circle(int x, int y, int r, bit drain);
      circle_type c;
      c.cx     = COORD_W'(x);
      c.cy     = COORD_W'(y);
      c.radius = RADIUS_W'(r);
      // every third block of 30 items is sent back to back
      c.gap    = ((circle_q.size() / 30) % 3 == 1) ? 0 : $urandom_range(0, 12);
      c.drain  = drain;
      circle_q.push_back(c);
   endfunction

   function automatic int pick_coord();
      case ($urandom_range(0, 7))
         0: return -16384;
         1: return 16383;
         2: return $urandom_range(0, 1) ? 0 : -1;
         default: return int'($signed(COORD_W'($urandom)));
      endcase
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         idle_cnt     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            rasterize_circle(in_flight);
            circles_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (circle_q.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (idle_cnt < circle_q[0].gap) begin
               req_ch.valid <= 1'b0;
               idle_cnt     <= idle_cnt + 1;
            end else if (circle_q[0].drain && span_q.size() != 0) begin
               req_ch.valid <= 1'b0;
            end else begin
               in_flight        = circle_q.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.center_x <= in_flight.cx;
               req_ch.center_y <= in_flight.cy;
               req_ch.radius   <= in_flight.radius;
               idle_cnt        <= 0;
            end
         end
      end
   end

   // receiver and span check
   always @(posedge clock) begin
      int unsigned pause;
      span_type    want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if (span_q.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
               $display("unexpected span: row %0d left %0d right %0d last %0b",
                        rsp_ch.span_row, rsp_ch.span_left, rsp_ch.span_right,
                        rsp_ch.last_span);
         end else begin
            want = span_q.pop_front();
            if (rsp_ch.span_row !== want.row || rsp_ch.span_left !== want.left ||
                rsp_ch.span_right !== want.right || rsp_ch.last_span !== want.last) begin
               n_errors++;
               if (n_errors <= 10)
                  $display({"span mismatch: exp row %0d left %0d right %0d last %0b,",
                            " got row %0d left %0d right %0d last %0b"},
                           want.row, want.left, want.right, want.last,
                           rsp_ch.span_row, rsp_ch.span_left, rsp_ch.span_right,
                           rsp_ch.last_span);
            end
         end
         spans_seen++;
         if (spans_seen == LONG_HOLD_AT)
            pause = LONG_HOLD;
         else if ((spans_seen / 100) % 3 == 2)
            pause = 0;
         else
            pause = $urandom_range(0, 12);
         stall_left   <= pause;
         rsp_ch.ready <= (pause == 0);
      end else if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= (stall_left == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin
      int r;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.center_x = '0;
      req_ch.center_y = '0;
      req_ch.radius   = '0;
      rsp_ch.ready    = 1'b0;
      circles_taken   = 0;
      spans_seen      = 0;
      n_errors        = 0;

      // corners, empty circles, smallest and largest radius
      add_circle(0, 0, 0, 0);
      add_circle(0, 0, 1, 0);
      add_circle(0, 0, 2, 0);
      add_circle(16383, 16383, 31, 0);
      add_circle(-16384, -16384, 31, 0);
      add_circle(16383, -16384, 31, 0);
      add_circle(-16384, 16383, 31, 0);
      add_circle(-16384, -16384, 0, 0);
      add_circle(16383, 16383, 0, 0);
      add_circle(-16384, 16383, 1, 0);
      add_circle(16383, -16384, 1, 0);
      add_circle(-1, -1, 3, 0);
      add_circle(100, -100, 4, 0);
      add_circle(-5000, 5000, 5, 0);
      add_circle(21845 - 32768, 10922, 7, 0);
      add_circle(10922, -10923, 8, 0);
      add_circle(0, 0, 15, 0);
      add_circle(-1, 0, 16, 0);
      add_circle(1, 1, 0, 0);
      add_circle(2, 2, 0, 0);
      add_circle(3, 3, 1, 0);

      for (int n = 0; n < N_RANDOM; n++) begin
         case ($urandom_range(0, 3))
            0: r = $urandom_range(0, 3);
            1: r = $urandom_range(24, 31);
            default: r = $urandom_range(0, 31);
         endcase
         add_circle(pick_coord(), pick_coord(), r, n == DRAIN_AT);
      end
      n_circles = circle_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (circles_taken != n_circles)
         @(posedge clock);
      while (span_q.size() != 0)
         @(posedge clock);
      // anything still coming out now is an extra span
      repeat (200) @(posedge clock);

      if (n_errors == 0)
         $display("tb_circle_span_rasterizer_core: PASS");
      else
         $display("tb_circle_span_rasterizer_core: FAIL");
      $finish;
   end

   initial begin
      #(8 * 1000000);
      $display("tb_circle_span_rasterizer_core: FAIL");
      $finish;
   end

endmodule
